[rtl/sm83_pkg.sv]
// Package for the SM83 instruction subset executor.
// Holds the instruction and result word types, opcodes, status codes and fixed addresses.
// No dependencies.
package sm83_pkg;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
        logic [7:0] read_data;
    } instr_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] next_pc;
        logic [7:0]  acc_out;
        logic [7:0]  b_out;
        logic [7:0]  c_out;
        logic [15:0] hl_out;
        logic [3:0]  flags_out;
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [15:0] read_address;
    } result_word_t;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PC_RANGE = 2'd1;
    localparam logic [1:0] ST_BAD_OP   = 2'd2;

    // Opcodes
    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_DEC_B    = 8'h05;
    localparam logic [7:0] OP_LD_B_D8  = 8'h06;
    localparam logic [7:0] OP_DEC_C    = 8'h0D;
    localparam logic [7:0] OP_LD_C_D8  = 8'h0E;
    localparam logic [7:0] OP_RRCA     = 8'h0F;
    localparam logic [7:0] OP_JR_NZ    = 8'h20;
    localparam logic [7:0] OP_LD_HL_16 = 8'h21;
    localparam logic [7:0] OP_LDD_HL_A = 8'h32;
    localparam logic [7:0] OP_LD_HL_D8 = 8'h36;
    localparam logic [7:0] OP_LD_A_D8  = 8'h3E;
    localparam logic [7:0] OP_XOR_B    = 8'hA8;
    localparam logic [7:0] OP_XOR_A    = 8'hAF;
    localparam logic [7:0] OP_JP_A16   = 8'hC3;
    localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
    localparam logic [7:0] OP_LD_C_A   = 8'hE2;
    localparam logic [7:0] OP_LD_A16_A = 8'hEA;
    localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
    localparam logic [7:0] OP_DI       = 8'hF3;
    localparam logic [7:0] OP_EI       = 8'hFB;
    localparam logic [7:0] OP_CP_D8    = 8'hFE;

    // Fixed addresses and reset values
    localparam logic [15:0] PC_ENTRY = 16'h0100;
    localparam logic [7:0]  IO_PAGE  = 8'hFF;
    localparam logic [15:0] IE_ADDR  = 16'hFFFF;

endpackage

[rtl/sm83_instruction_subset_executor_top.sv]
// Top level of the SM83 instruction subset executor.
// Depends on sm83_pkg for word types, opcodes and status codes.
//
//  channel  | direction | handshake                   | word
//  ---------+-----------+-----------------------------+----------------
//  instr    | in        | instr_valid / instr_ready   | instr_word_t
//  result   | out       | result_valid / result_ready | result_word_t
//
// One instruction per cycle sustained while the result is not stalled. An
// accepted instruction word sits in the instruction register while decode,
// the 8-bit ALU and the PC adder feed the result register and the
// architectural registers.
// Reset loads PC with 0x0100 and clears A, B, C, HL, the flags and both valid bits.
// A stalled result holds the result register; the instruction register still
// takes a word while it is empty, and further words wait for the stall to end.
module sm83_instruction_subset_executor_top
    import sm83_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         instr_valid,
    output logic         instr_ready,
    input  instr_word_t  instr,
    output logic         result_valid,
    input  logic         result_ready,
    output result_word_t result
);

    // Instruction register
    logic        ir_valid_reg;
    instr_word_t ir_reg;

    // Architectural state
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  b_reg, b_next;
    logic [7:0]  c_reg, c_next;
    logic [15:0] hl_reg, hl_next;
    logic [3:0]  f_reg, f_next;

    // Result register
    logic         res_valid_reg;
    result_word_t res_reg, res_next;

    logic exec_fire;

    // Execute whenever the result register is empty or being drained.
    assign exec_fire   = ir_valid_reg && (!res_valid_reg || result_ready);
    assign instr_ready = !ir_valid_reg || exec_fire;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg <= 1'b0;
        end
        else if (instr_ready)
        begin
            ir_valid_reg <= instr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr_ready && instr_valid)
        begin
            ir_reg <= instr;
        end
    end

    // Execute stage: decode, ALU, PC update and memory write request.
    logic [15:0] pc_inc1, pc_inc2, pc_inc3, jr_target, imm16;
    logic [7:0]  dec_src, dec_res, xor_res;
    logic [3:0]  dec_flags, cp_flags;
    logic [7:0]  op, lo;

    always_comb
    begin
        op        = ir_reg.opcode;
        lo        = ir_reg.imm_low;
        imm16     = {ir_reg.imm_high, ir_reg.imm_low};
        pc_inc1   = pc_reg + 16'd1;
        pc_inc2   = pc_reg + 16'd2;
        pc_inc3   = pc_reg + 16'd3;
        jr_target = pc_inc2 + {{8{lo[7]}}, lo};

        // DEC B and DEC C share one decrementer; carry is kept.
        dec_src   = (op == OP_DEC_C) ? c_reg : b_reg;
        dec_res   = dec_src - 8'd1;
        dec_flags = {(dec_res == 8'd0), 1'b1, (dec_src[3:0] == 4'd0), f_reg[0]};

        // CP d8: half borrow from the low nibbles.
        cp_flags  = {(a_reg == lo), 1'b1, (a_reg[3:0] < lo[3:0]), (lo > a_reg)};

        xor_res   = a_reg ^ b_reg;

        pc_next  = pc_inc1;
        a_next   = a_reg;
        b_next   = b_reg;
        c_next   = c_reg;
        hl_next  = hl_reg;
        f_next   = f_reg;

        res_next               = '0;
        res_next.status        = ST_OK;

        case (op)
            OP_NOP:
            begin
            end
            OP_DEC_B:
            begin
                b_next = dec_res;
                f_next = dec_flags;
            end
            OP_DEC_C:
            begin
                c_next = dec_res;
                f_next = dec_flags;
            end
            OP_LD_B_D8:
            begin
                b_next  = lo;
                pc_next = pc_inc2;
            end
            OP_LD_C_D8:
            begin
                c_next  = lo;
                pc_next = pc_inc2;
            end
            OP_LD_A_D8:
            begin
                a_next  = lo;
                pc_next = pc_inc2;
            end
            OP_RRCA:
            begin
                a_next = {a_reg[0], a_reg[7:1]};
                f_next = {3'b000, a_reg[0]};
            end
            OP_JR_NZ:
            begin
                pc_next = f_reg[3] ? pc_inc2 : jr_target;
            end
            OP_LD_HL_16:
            begin
                hl_next = imm16;
                pc_next = pc_inc3;
            end
            OP_LDD_HL_A:
            begin
                res_next.write_enable  = 1'b1;
                res_next.write_address = hl_reg;
                res_next.write_data    = a_reg;
                hl_next                = hl_reg - 16'd1;
            end
            OP_LD_HL_D8:
            begin
                res_next.write_enable  = 1'b1;
                res_next.write_address = hl_reg;
                res_next.write_data    = lo;
                pc_next                = pc_inc2;
            end
            OP_XOR_B:
            begin
                a_next = xor_res;
                f_next = {(xor_res == 8'd0), 3'b000};
            end
            OP_XOR_A:
            begin
                a_next = 8'd0;
                f_next = 4'b1000;
            end
            OP_JP_A16:
            begin
                pc_next = imm16;
            end
            OP_LDH_N_A:
            begin
                res_next.write_enable  = 1'b1;
                res_next.write_address = {IO_PAGE, lo};
                res_next.write_data    = a_reg;
                pc_next                = pc_inc2;
            end
            OP_LD_C_A:
            begin
                res_next.write_enable  = 1'b1;
                res_next.write_address = {IO_PAGE, c_reg};
                res_next.write_data    = a_reg;
            end
            OP_LD_A16_A:
            begin
                res_next.write_enable  = 1'b1;
                res_next.write_address = imm16;
                res_next.write_data    = a_reg;
                pc_next                = pc_inc3;
            end
            OP_LDH_A_N:
            begin
                res_next.read_address = {IO_PAGE, lo};
                a_next                = ir_reg.read_data;
                pc_next               = pc_inc2;
            end
            OP_DI:
            begin
                res_next.write_enable  = 1'b1;
                res_next.write_address = IE_ADDR;
                res_next.write_data    = 8'd0;
            end
            OP_EI:
            begin
                res_next.write_enable  = 1'b1;
                res_next.write_address = IE_ADDR;
                res_next.write_data    = 8'd1;
            end
            OP_CP_D8:
            begin
                f_next  = cp_flags;
                pc_next = pc_inc2;
            end
            default:
            begin
                // Unlisted opcode: count the fetch, change nothing else.
                res_next.status = ST_BAD_OP;
            end
        endcase

        // PC at or above 32 KiB: freeze everything and drop the write.
        if (pc_reg[15])
        begin
            pc_next  = pc_reg;
            a_next   = a_reg;
            b_next   = b_reg;
            c_next   = c_reg;
            hl_next  = hl_reg;
            f_next   = f_reg;
            res_next = '0;
            res_next.status = ST_PC_RANGE;
        end

        res_next.next_pc   = pc_next;
        res_next.acc_out   = a_next;
        res_next.b_out     = b_next;
        res_next.c_out     = c_next;
        res_next.hl_out    = hl_next;
        res_next.flags_out = f_next;
    end

    // Architectural registers advance only when an instruction executes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_ENTRY;
            a_reg  <= 8'd0;
            b_reg  <= 8'd0;
            c_reg  <= 8'd0;
            hl_reg <= 16'd0;
            f_reg  <= 4'd0;
        end
        else if (exec_fire)
        begin
            pc_reg <= pc_next;
            a_reg  <= a_next;
            b_reg  <= b_next;
            c_reg  <= c_next;
            hl_reg <= hl_next;
            f_reg  <= f_next;
        end
    end

    // Result register: hold while stalled, load on execute.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

[rtl/sm83_exec_chk.sv]
// Port-level checker for the SM83 instruction subset executor, with its bind.
// Depends on sm83_pkg and on sm83_instruction_subset_executor_top.
module sm83_exec_chk
    import sm83_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         result_valid,
    input logic         result_ready,
    input result_word_t result
);

    // Hold a stalled result word.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word dropped or changed while stalled");

    // A faulting instruction neither writes nor reads memory.
    a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |->
            !result.write_enable && result.read_address == 16'd0)
        else $error("memory access on a faulting instruction");

    // Drive zero address and data when no write is requested.
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.write_enable |->
            result.write_address == 16'd0 && result.write_data == 8'd0)
        else $error("write address or data nonzero without a write");

    // The range fault reports a PC at or above 32 KiB.
    a_range_pc: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_PC_RANGE |-> result.next_pc[15])
        else $error("range fault with PC below 32 KiB");

endmodule

bind sm83_instruction_subset_executor_top sm83_exec_chk u_sm83_exec_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
